[rtl/yidm_pkg.sv]
// ----------------------------------------------------------------------------
// yidm_pkg
// Shared types and constants for the Yee grid design index map.
// ----------------------------------------------------------------------------
package yidm_pkg;

    localparam int ROW_W      = 21;
    localparam int COL_W      = 20;
    localparam int COORD_W    = 8;
    localparam int OFF_W      = 8;
    localparam int BOX_W      = 7;
    localparam int MODE_W     = 2;
    localparam int COMP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int GRID_X_DEF      = 64;
    localparam int GRID_Y_DEF      = 64;
    localparam int GRID_Z_DEF      = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // field vector components
    localparam int NUM_COMP = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LAYERS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd7;

    // mode bits
    localparam int MODE_SLAB_BIT  = 0;
    localparam int MODE_ANISO_BIT = 1;

    typedef enum logic [1:0] {
        KIND_MISS  = 2'd0,
        KIND_CELL  = 2'd1,
        KIND_LAYER = 2'd2
    } kind_t;

    typedef struct packed {
        logic [OFF_W-1:0]  off_x;
        logic [OFF_W-1:0]  off_y;
        logic [OFF_W-1:0]  off_z;
        logic [BOX_W-1:0]  box_x;
        logic [BOX_W-1:0]  box_y;
        logic [BOX_W-1:0]  box_z;
        logic [BOX_W-1:0]  extra_layers;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    // classified row: dz holds the layer number for a layer hit
    typedef struct packed {
        kind_t             kind;
        logic [BOX_W-1:0]  dx;
        logic [BOX_W-1:0]  dy;
        logic [BOX_W-1:0]  dz;
        logic [COMP_W-1:0] comp;
    } item_t;

endpackage

[rtl/yidm_cdiv.sv]
// ----------------------------------------------------------------------------
// yidm_cdiv
// Two-stage divide by a constant: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
module yidm_cdiv #(
    parameter  int DIV    = 64,
    parameter  int NUM_W  = 21,
    localparam int QW_RAW = $clog2(((2**NUM_W) - 1) / DIV + 1),
    localparam int QW     = (QW_RAW > 0) ? QW_RAW : 1,
    localparam int RW     = (DIV > 1) ? $clog2(DIV) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_in,
    output logic [QW-1:0]    quo,
    output logic [RW-1:0]    rem
);
    localparam int SHIFT  = NUM_W + $clog2(DIV);
    localparam int MW     = NUM_W + 2;
    localparam int PW     = NUM_W + MW;
    // ceil(2^SHIFT / DIV) is exact for every numerator below 2^NUM_W
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [PW-1:0]    prod_reg;
    logic [NUM_W-1:0] num_reg;
    logic [QW-1:0]    quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [QW-1:0]    q_est;
    logic [NUM_W-1:0] back_mul;

    always_comb begin
        q_est    = QW'(prod_reg >> SHIFT);
        back_mul = NUM_W'(NUM_W'(q_est) * NUM_W'(DIV));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(num_in) * PW'(RECIP);
            num_reg  <= num_in;
            quo_reg  <= q_est;
            rem_reg  <= RW'(num_reg - back_mul);
        end
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

[rtl/yidm_front.sv]
// ----------------------------------------------------------------------------
// yidm_front
// Splits a row index into z, y, x and component, then classifies the cell
// against the design box.
// ----------------------------------------------------------------------------
module yidm_front
    import yidm_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ROW_W-1:0] s_row_index,
    output logic             push,
    output item_t            push_item,
    input  logic             q_ready
);
    localparam int ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int Q1RAW = $clog2(((2**ROW_W) - 1) / GRID_Z + 1);
    localparam int Q1W   = (Q1RAW > 0) ? Q1RAW : 1;
    localparam int Q2RAW = $clog2(((2**Q1W) - 1) / GRID_Y + 1);
    localparam int Q2W   = (Q2RAW > 0) ? Q2RAW : 1;
    localparam int Q3RAW = $clog2(((2**Q2W) - 1) / GRID_X + 1);
    localparam int Q3W   = (Q3RAW > 0) ? Q3RAW : 1;
    localparam int Q4RAW = $clog2(((2**Q3W) - 1) / NUM_COMP + 1);
    localparam int Q4W   = (Q4RAW > 0) ? Q4RAW : 1;
    localparam int NSTG  = 9;

    logic                adv;
    logic [NSTG-1:0]     valid_reg;
    logic [Q1W-1:0]      q1;
    logic [Q2W-1:0]      q2;
    logic [Q3W-1:0]      q3;
    logic [Q4W-1:0]      q4;
    logic [ZW-1:0]       z_rem;
    logic [YW-1:0]       y_rem;
    logic [XW-1:0]       x_rem;
    logic [COMP_W-1:0]   c_rem;
    logic [ZW-1:0]       z_dly_reg [6];
    logic [YW-1:0]       y_dly_reg [4];
    logic [XW-1:0]       x_dly_reg [2];
    item_t               item_reg;
    item_t               item_next;
    logic signed [9:0]   dx;
    logic signed [9:0]   dy;
    logic signed [9:0]   dz;
    logic [8:0]          lay;
    logic                in_x;
    logic                in_y;

    // whole pipe holds while the last stage cannot drain
    assign adv     = !valid_reg[NSTG-1] || q_ready;
    assign s_ready = adv;

    yidm_cdiv #(.DIV(GRID_Z), .NUM_W(ROW_W)) u_div_z (
        .aclk(aclk), .en(adv), .num_in(s_row_index), .quo(q1), .rem(z_rem)
    );
    yidm_cdiv #(.DIV(GRID_Y), .NUM_W(Q1W)) u_div_y (
        .aclk(aclk), .en(adv), .num_in(q1), .quo(q2), .rem(y_rem)
    );
    yidm_cdiv #(.DIV(GRID_X), .NUM_W(Q2W)) u_div_x (
        .aclk(aclk), .en(adv), .num_in(q2), .quo(q3), .rem(x_rem)
    );
    yidm_cdiv #(.DIV(NUM_COMP), .NUM_W(Q3W)) u_div_c (
        .aclk(aclk), .en(adv), .num_in(q3), .quo(q4), .rem(c_rem)
    );

    always_comb begin
        dx = $signed({2'b00, COORD_W'(x_dly_reg[1])}) - $signed({{2{cfg.off_x[7]}}, cfg.off_x});
        dy = $signed({2'b00, COORD_W'(y_dly_reg[3])}) - $signed({{2{cfg.off_y[7]}}, cfg.off_y});
        dz = $signed({2'b00, COORD_W'(z_dly_reg[5])}) - $signed({{2{cfg.off_z[7]}}, cfg.off_z});
        in_x = !dx[9] && (dx[8:0] < {2'b00, cfg.box_x});
        in_y = !dy[9] && (dy[8:0] < {2'b00, cfg.box_y});
        lay  = dz[8:0] - {2'b00, cfg.box_z};

        item_next.kind = KIND_MISS;
        item_next.dx   = dx[BOX_W-1:0];
        item_next.dy   = dy[BOX_W-1:0];
        item_next.dz   = dz[BOX_W-1:0];
        item_next.comp = c_rem;
        if (in_x && in_y && !dz[9]) begin
            if (dz[8:0] < {2'b00, cfg.box_z}) begin
                item_next.kind = KIND_CELL;
            end else if (lay < {2'b00, cfg.extra_layers}) begin
                item_next.kind = KIND_LAYER;
                item_next.dz   = lay[BOX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NSTG-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            z_dly_reg[0] <= z_rem;
            for (int i = 1; i < 6; i++) z_dly_reg[i] <= z_dly_reg[i-1];
            y_dly_reg[0] <= y_rem;
            for (int i = 1; i < 4; i++) y_dly_reg[i] <= y_dly_reg[i-1];
            x_dly_reg[0] <= x_rem;
            x_dly_reg[1] <= x_dly_reg[0];
            item_reg     <= item_next;
        end
    end

    assign push      = valid_reg[NSTG-1] && q_ready;
    assign push_item = item_reg;

    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NSTG-2] |-> c_rem < COMP_W'(NUM_COMP))
        else $error("component remainder out of range");

    // quotient past the component is bounded by the row width
    a_comp_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NSTG-2] |-> q4 <= Q4W'(((2**Q3W) - 1) / NUM_COMP))
        else $error("component quotient out of range");

endmodule

[rtl/yidm_queue.sv]
// ----------------------------------------------------------------------------
// yidm_queue
// Short register queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module yidm_queue
    import yidm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  pop,
    output item_t pop_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> in_ready)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

[rtl/yidm_back.sv]
// ----------------------------------------------------------------------------
// yidm_back
// Computes the design column of a classified row and holds the result.
// ----------------------------------------------------------------------------
module yidm_back
    import yidm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    output logic             pop,
    input  item_t            q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_hit,
    output logic [COL_W-1:0] m_column
);
    logic             adv;
    logic             slab;
    logic             aniso;

    logic             b1_valid_reg;
    item_t            b1_item_reg;
    logic [COL_W-1:0] b1_plane_reg;
    logic [COL_W-1:0] b1_volxy_reg;

    logic             b2_valid_reg;
    item_t            b2_item_reg;
    logic [COL_W-1:0] b2_cell_reg;
    logic [COL_W-1:0] b2_vol_reg;

    logic             out_valid_reg;
    logic             hit_reg;
    logic [COL_W-1:0] col_reg;
    logic             hit_next;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] base;

    assign slab  = cfg.mode[MODE_SLAB_BIT];
    assign aniso = cfg.mode[MODE_ANISO_BIT];
    assign adv   = !out_valid_reg || m_ready;
    assign pop   = adv && q_valid;

    always_comb begin
        base     = aniso ? COL_W'(b2_vol_reg + (b2_vol_reg << 1)) : b2_vol_reg;
        hit_next = 1'b0;
        col_next = '0;
        case (b2_item_reg.kind)
            KIND_CELL: begin
                hit_next = 1'b1;
                col_next = aniso ? COL_W'(b2_cell_reg + COL_W'(b2_item_reg.comp) * b2_vol_reg)
                                 : b2_cell_reg;
            end
            KIND_LAYER: begin
                hit_next = 1'b1;
                col_next = COL_W'(base + COL_W'(b2_item_reg.dz));
            end
            default: begin
                hit_next = 1'b0;
                col_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_item_reg  <= q_item;
            b1_plane_reg <= COL_W'(COL_W'(q_item.dx) * COL_W'(cfg.box_y) + COL_W'(q_item.dy));
            b1_volxy_reg <= COL_W'(COL_W'(cfg.box_x) * COL_W'(cfg.box_y));

            b2_item_reg  <= b1_item_reg;
            b2_cell_reg  <= slab ? b1_plane_reg
                                 : COL_W'(b1_plane_reg * COL_W'(cfg.box_z)
                                          + COL_W'(b1_item_reg.dz));
            b2_vol_reg   <= slab ? b1_volxy_reg : COL_W'(b1_volxy_reg * COL_W'(cfg.box_z));

            hit_reg      <= hit_next;
            col_reg      <= col_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_hit    = hit_reg;
    assign m_column = col_reg;

endmodule

[rtl/yee_grid_design_index_map.sv]
// ----------------------------------------------------------------------------
// yee_grid_design_index_map
// Maps a Yee field-grid row index to a design-box hit flag and column.
//
// Input channel s_valid/s_ready/s_row_index: one flattened row index per
// beat. Result channel m_valid/m_ready/m_hit/m_column: one beat per input,
// in order; m_column is zero on a miss.
// Configuration: cfg_we writes cfg_data into register cfg_index (offsets,
// box extents, extra layers, mode) in the cycle it is high. Write only
// while no beat is in flight.
// Throughput: one row per cycle while s_ready is high. The beat passes
// thirteen register stages, the first loaded at the accepting edge: nine in
// the front pipe (four two-stage divide-by-constant units plus the box
// classifier), one queue entry, two column multiply stages and the output
// register.
// Reset clears every pipe and queue valid and sets the registers to their
// defaults (box extents 1, all else 0). When the receiver stalls, the back
// pipe holds, the four-entry queue fills, and only then does the front pipe
// hold and drop s_ready.
// ----------------------------------------------------------------------------
module yee_grid_design_index_map
    import yidm_pkg::*;
#(
    parameter int GRID_X      = GRID_X_DEF,
    parameter int GRID_Y      = GRID_Y_DEF,
    parameter int GRID_Z      = GRID_Z_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ROW_W-1:0]      s_row_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [COL_W-1:0]      m_column
);
    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    item_t pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{off_x: '0, off_y: '0, off_z: '0,
                         box_x: BOX_W'(1), box_y: BOX_W'(1), box_z: BOX_W'(1),
                         extra_layers: '0, mode: '0};
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OFF_X:        cfg_reg.off_x        <= cfg_data;
                REG_OFF_Y:        cfg_reg.off_y        <= cfg_data;
                REG_OFF_Z:        cfg_reg.off_z        <= cfg_data;
                REG_BOX_X:        cfg_reg.box_x        <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:        cfg_reg.box_y        <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:        cfg_reg.box_z        <= cfg_data[BOX_W-1:0];
                REG_EXTRA_LAYERS: cfg_reg.extra_layers <= cfg_data[BOX_W-1:0];
                REG_MODE:         cfg_reg.mode         <= cfg_data[MODE_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    yidm_front #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row_index(s_row_index),
        .push       (push),
        .push_item  (push_item),
        .q_ready    (q_ready)
    );

    yidm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .in_ready (q_ready),
        .out_valid(q_valid),
        .pop      (pop),
        .pop_item (pop_item)
    );

    yidm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .pop     (pop),
        .q_item  (pop_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_hit   (m_hit),
        .m_column(m_column)
    );

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_column == '0)
        else $error("nonzero column on a miss");

endmodule
